// ----- sv/bcat_pkg.sv -----
package bcat_pkg;

  // Command codes of the input channel.
  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_ALLOC = 3'd2,
    CMD_FREE  = 3'd3,
    CMD_STATS = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_BROKEN    = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALLOC    = 1'd1;

  // Field widths of the channels.
  localparam int CMD_W   = 3;
  localparam int BLK_W   = 12;
  localparam int ENTRY_W = 16;
  localparam int CNT_W   = 13;

  // Register reset values.
  localparam logic [BLK_W-1:0] START_RESET = 12'd64;
  localparam logic [CNT_W-1:0] MAX_RESET   = 13'd4016;

  // Special entry codes.
  localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'h0000;
  localparam logic [ENTRY_W-1:0] ENTRY_END  = 16'hFFFF;
  localparam logic [ENTRY_W-1:0] ENTRY_BAD  = 16'hFFFE;

  // One result item.
  typedef struct packed {
    status_e            status;
    logic [ENTRY_W-1:0] value;
    logic [CNT_W-1:0]   freed;
    logic [CNT_W-1:0]   free_total;
    logic [CNT_W-1:0]   used_total;
    logic [CNT_W-1:0]   bad_total;
  } res_t;

endpackage

// ----- sv/bcat_ram.sv -----
module bcat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bcat_ctrl.sv -----
module bcat_ctrl #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bcat_pkg::CMD_W-1:0]     in_cmd,
  input  logic [bcat_pkg::BLK_W-1:0]     in_blk,
  input  logic [bcat_pkg::ENTRY_W-1:0]   in_val,
  input  logic [bcat_pkg::CNT_W-1:0]     in_cnt,
  input  logic [bcat_pkg::BLK_W-1:0]     search_start,
  input  logic [bcat_pkg::CNT_W-1:0]     max_alloc,
  input  logic                           out_free,
  output logic                           res_load,
  output bcat_pkg::res_t                 res,
  output logic                           mem_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr,
  output logic [bcat_pkg::ENTRY_W-1:0]   mem_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr,
  input  logic [bcat_pkg::ENTRY_W-1:0]   mem_rdata
);
  import bcat_pkg::*;

  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int RAW  = (IW + 1 > 13) ? IW + 1 : 13;
  localparam int CMPW = (CW > 13) ? CW : 13;
  localparam int PW   = ENTRY_W + 1;

  typedef enum logic [9:0] {
    S_CLEAR     = 10'b0000000001,
    S_IDLE      = 10'b0000000010,
    S_DISPATCH  = 10'b0000000100,
    S_READ_WAIT = 10'b0000001000,
    S_SCAN      = 10'b0000010000,
    S_LINK      = 10'b0000100000,
    S_LINK_END  = 10'b0001000000,
    S_FREE_RD   = 10'b0010000000,
    S_FREE_WR   = 10'b0100000000,
    S_RESP      = 10'b1000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [RAW-1:0]       ra_r, ra_nxt;
  logic                 pv_r, pv_nxt;
  logic [IW-1:0]        pa_r, pa_nxt;
  logic [CW-1:0]        cnt0_r, cnt0_nxt;
  logic [CW-1:0]        cnt1_r, cnt1_nxt;
  logic [CW-1:0]        cnt2_r, cnt2_nxt;
  logic [CW-1:0]        taken_r, taken_nxt;
  logic [IW-1:0]        prev_r, prev_nxt;
  logic [IW-1:0]        head_r, head_nxt;
  logic [ENTRY_W-1:0]   cur_r, cur_nxt;
  cmd_e                 cmd_r, cmd_nxt;
  logic [BLK_W-1:0]     blk_r, blk_nxt;
  logic [ENTRY_W-1:0]   val_r, val_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic                 alloc_mode_r, alloc_mode_nxt;
  res_t                 res_r, res_nxt;
  logic                 issue;
  logic                 blk_ok;
  logic [IW-1:0]        blk_idx;

  assign issue    = (ra_r < RAW'(TABLE_DEPTH));
  assign blk_ok   = (RAW'(blk_r) < RAW'(TABLE_DEPTH));
  assign blk_idx  = IW'(blk_r);
  assign in_ready = (state_r == S_IDLE);
  assign res      = res_r;

  // Command sequencer: every table access goes through the memory ports.
  always_comb begin
    state_nxt      = state_r;
    ra_nxt         = ra_r;
    pv_nxt         = 1'b0;
    pa_nxt         = ra_r[IW-1:0];
    cnt0_nxt       = cnt0_r;
    cnt1_nxt       = cnt1_r;
    cnt2_nxt       = cnt2_r;
    taken_nxt      = taken_r;
    prev_nxt       = prev_r;
    head_nxt       = head_r;
    cur_nxt        = cur_r;
    cmd_nxt        = cmd_r;
    blk_nxt        = blk_r;
    val_nxt        = val_r;
    n_nxt          = n_r;
    alloc_mode_nxt = alloc_mode_r;
    res_nxt        = res_r;
    res_load       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = prev_r;
    mem_wdata      = ENTRY_FREE;
    mem_raddr      = ra_r[IW-1:0];

    unique case (state_r)
      // Clearing pass after reset, one entry a cycle.
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ra_r[IW-1:0];
        ra_nxt    = ra_r + 1'b1;
        if (ra_r == RAW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_e'(in_cmd);
          blk_nxt   = in_blk;
          val_nxt   = in_val;
          n_nxt     = in_cnt;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_nxt = '0;
        unique case (cmd_r)
          CMD_WRITE: begin
            mem_we    = blk_ok;
            mem_waddr = blk_idx;
            mem_wdata = val_r;
            state_nxt = S_RESP;
          end
          CMD_READ: begin
            mem_raddr = blk_idx;
            state_nxt = blk_ok ? S_READ_WAIT : S_RESP;
          end
          CMD_ALLOC: begin
            if (n_r == '0 || n_r > max_alloc) begin
              res_nxt.status = ST_TOO_LARGE;
              res_nxt.value  = ENTRY_END;
              state_nxt      = S_RESP;
            end else begin
              ra_nxt         = RAW'(search_start);
              cnt0_nxt       = '0;
              alloc_mode_nxt = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          CMD_FREE: begin
            cur_nxt   = ENTRY_W'(blk_r);
            cnt0_nxt  = '0;
            state_nxt = S_FREE_RD;
          end
          CMD_STATS: begin
            ra_nxt         = '0;
            cnt0_nxt       = '0;
            cnt1_nxt       = '0;
            cnt2_nxt       = '0;
            alloc_mode_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_READ_WAIT: begin
        res_nxt       = '0;
        res_nxt.value = mem_rdata;
        state_nxt     = S_RESP;
      end
      // Counting scan: one read issued and one entry classified per cycle.
      S_SCAN: begin
        if (issue) begin
          ra_nxt = ra_r + 1'b1;
          pv_nxt = 1'b1;
        end
        if (pv_r) begin
          if (mem_rdata == ENTRY_FREE) begin
            cnt0_nxt = cnt0_r + 1'b1;
          end else if (mem_rdata == ENTRY_BAD) begin
            cnt2_nxt = cnt2_r + 1'b1;
          end else begin
            cnt1_nxt = cnt1_r + 1'b1;
          end
        end
        if (!issue && !pv_r) begin
          res_nxt = '0;
          if (!alloc_mode_r) begin
            res_nxt.free_total = CNT_W'(cnt0_r);
            res_nxt.used_total = CNT_W'(cnt1_r);
            res_nxt.bad_total  = CNT_W'(cnt2_r);
            state_nxt          = S_RESP;
          end else if (CMPW'(cnt0_r) > CMPW'(n_r)) begin
            ra_nxt    = RAW'(search_start);
            taken_nxt = '0;
            state_nxt = S_LINK;
          end else begin
            res_nxt.status = ST_NO_SPACE;
            res_nxt.value  = ENTRY_END;
            state_nxt      = S_RESP;
          end
        end
      end
      // Linking scan: each free block found is chained behind the previous one.
      S_LINK: begin
        if (issue) begin
          ra_nxt = ra_r + 1'b1;
          pv_nxt = 1'b1;
        end
        if (pv_r && mem_rdata == ENTRY_FREE) begin
          if (taken_r == '0) begin
            head_nxt = pa_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = prev_r;
            mem_wdata = ENTRY_W'(pa_r);
          end
          prev_nxt  = pa_r;
          taken_nxt = taken_r + 1'b1;
          if (CMPW'(taken_r) + 1'b1 == CMPW'(n_r)) begin
            pv_nxt    = 1'b0;
            state_nxt = S_LINK_END;
          end
        end
      end
      S_LINK_END: begin
        mem_we        = 1'b1;
        mem_waddr     = prev_r;
        mem_wdata     = ENTRY_END;
        res_nxt       = '0;
        res_nxt.value = ENTRY_W'(head_r);
        state_nxt     = S_RESP;
      end
      // Chain walk: read an entry, then clear it and follow its link.
      S_FREE_RD: begin
        if (!(PW'(cur_r) < PW'(TABLE_DEPTH)) || CMPW'(cnt0_r) >= CMPW'(TABLE_DEPTH)) begin
          res_nxt        = '0;
          res_nxt.status = ST_BROKEN;
          res_nxt.freed  = CNT_W'(cnt0_r);
          state_nxt      = S_RESP;
        end else begin
          mem_raddr = cur_r[IW-1:0];
          state_nxt = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r[IW-1:0];
        cnt0_nxt  = cnt0_r + 1'b1;
        if (mem_rdata[ENTRY_W-1]) begin
          res_nxt       = '0;
          res_nxt.freed = CNT_W'(cnt0_r + 1'b1);
          state_nxt     = S_RESP;
        end else begin
          cur_nxt   = mem_rdata;
          state_nxt = S_FREE_RD;
        end
      end
      S_RESP: begin
        res_load = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ra_r    <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ra_r    <= ra_nxt;
      pv_r    <= pv_nxt;
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    pa_r         <= pa_nxt;
    cnt0_r       <= cnt0_nxt;
    cnt1_r       <= cnt1_nxt;
    cnt2_r       <= cnt2_nxt;
    taken_r      <= taken_nxt;
    prev_r       <= prev_nxt;
    head_r       <= head_nxt;
    cur_r        <= cur_nxt;
    cmd_r        <= cmd_nxt;
    blk_r        <= blk_nxt;
    val_r        <= val_nxt;
    n_r          <= n_nxt;
    alloc_mode_r <= alloc_mode_nxt;
    res_r        <= res_nxt;
  end

endmodule

// ----- sv/block_chain_allocation_table_top.sv -----
// Block chain allocation table.
// Commands enter on the in_ channel (valid/ready) and each gives exactly one
// result on the out_ channel (valid/ready). Register writes on the cfg_
// channel are always taken and should only be issued while the block is idle.
// After reset the table is swept to all free, one entry a cycle, and
// in_ready stays low until the sweep is done.
// Write and read touch one entry; stats makes one counting scan of the whole
// table; allocate makes a counting scan and a linking scan from the search
// start, one table read per cycle; free reads and clears each block of the
// chain in turn and reports a broken chain.
// The table sits in one RAM with a single read and a single write port; its
// read port paces every scan and walk. One command is worked at a time.
// The result sits in an output register: a new command is taken while it
// waits, but a finished result waits inside the block until the output
// register is free again, so a stalled receiver stalls the next command.
module block_chain_allocation_table_top #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bcat_pkg::CMD_W-1:0]          in_cmd,
  input  logic [bcat_pkg::BLK_W-1:0]          in_block_number,
  input  logic signed [bcat_pkg::ENTRY_W-1:0] in_entry_value,
  input  logic [bcat_pkg::CNT_W-1:0]          in_block_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic signed [bcat_pkg::ENTRY_W-1:0] out_result_value,
  output logic [bcat_pkg::CNT_W-1:0]          out_freed_count,
  output logic [bcat_pkg::CNT_W-1:0]          out_free_total,
  output logic [bcat_pkg::CNT_W-1:0]          out_used_total,
  output logic [bcat_pkg::CNT_W-1:0]          out_bad_total,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcat_pkg::CNT_W-1:0]          cfg_wdata
);
  import bcat_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  logic [BLK_W-1:0]   start_r;
  logic [CNT_W-1:0]   max_r;
  logic               out_valid_r;
  res_t               out_r;
  res_t               res;
  logic               res_load;
  logic               out_free;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [IW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  bcat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bcat_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_blk       (in_block_number),
    .in_val       (in_entry_value),
    .in_cnt       (in_block_count),
    .search_start (start_r),
    .max_alloc    (max_r),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RESET;
      max_r   <= MAX_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SEARCH_START) begin
        start_r <= cfg_wdata[BLK_W-1:0];
      end
      if (cfg_index == CFG_MAX_ALLOC) begin
        max_r <= cfg_wdata;
      end
    end
  end

  // Output register: free when empty or when its result is transferred.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_result_value = out_r.value;
  assign out_freed_count  = out_r.freed;
  assign out_free_total   = out_r.free_total;
  assign out_used_total   = out_r.used_total;
  assign out_bad_total    = out_r.bad_total;

  // An accepted command always takes the sequencer out of idle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer stayed idle after an input transfer");

  // A result is only loaded into a free output register.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending output");

  // The clearing sweep blocks input right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("input accepted during table clear");

endmodule

// ----- test/block_chain_allocation_table_top_tb.sv -----
`timescale 1ns / 100ps

module block_chain_allocation_table_top_tb;
  import bcat_pkg::*;

  localparam int NBLK = 4096;

  // One command row of the directed table.
  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [BLK_W-1:0]   blk;
    logic [ENTRY_W-1:0] val;
    logic [CNT_W-1:0]   cnt;
  } cmd_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd;
  logic [BLK_W-1:0] in_block_number;
  logic signed [ENTRY_W-1:0] in_entry_value;
  logic [CNT_W-1:0] in_block_count;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_status;
  logic signed [ENTRY_W-1:0] out_result_value;
  logic [CNT_W-1:0] out_freed_count;
  logic [CNT_W-1:0] out_free_total;
  logic [CNT_W-1:0] out_used_total;
  logic [CNT_W-1:0] out_bad_total;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0] cfg_wdata;

  // Shadow copy of the link table and registers.
  logic [ENTRY_W-1:0] shadow_table [NBLK];
  logic [BLK_W-1:0] shadow_start;
  logic [CNT_W-1:0] shadow_max;

  res_t pending_results [$];
  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;

  block_chain_allocation_table_top #(.TABLE_DEPTH(NBLK)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("block_chain_allocation_table_top verification failed");
    $finish;
  end

  // Works out the result of one command and updates the shadow table.
  function automatic res_t apply_command(cmd_row_t c);
    res_t r;
    int avail;
    int taken;
    int prev;
    int cur;
    logic [ENTRY_W-1:0] nxt;
    r = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_WRITE: shadow_table[c.blk] = c.val;
      CMD_READ: r.value = shadow_table[c.blk];
      CMD_ALLOC: begin
        r.value = ENTRY_END;
        avail = 0;
        if (c.cnt == 0 || c.cnt > shadow_max) begin
          r.status = ST_TOO_LARGE;
        end else begin
          for (int i = shadow_start; i < NBLK; i++)
            if (shadow_table[i] == ENTRY_FREE) avail++;
          if (avail <= c.cnt) begin
            r.status = ST_NO_SPACE;
          end else begin
            taken = 0;
            prev = 0;
            for (int i = shadow_start; i < NBLK && taken < c.cnt; i++) begin
              if (shadow_table[i] == ENTRY_FREE) begin
                if (taken == 0) r.value = ENTRY_W'(i);
                else shadow_table[prev] = ENTRY_W'(i);
                prev = i;
                taken++;
              end
            end
            shadow_table[prev] = ENTRY_END;
          end
        end
      end
      CMD_FREE: begin
        cur = int'(c.blk);
        forever begin
          if (cur >= NBLK || r.freed >= NBLK) begin
            r.status = ST_BROKEN;
            break;
          end
          nxt = shadow_table[cur];
          shadow_table[cur] = ENTRY_FREE;
          r.freed++;
          if (nxt[ENTRY_W-1]) break;
          cur = int'(nxt);
        end
      end
      CMD_STATS: begin
        for (int i = 0; i < NBLK; i++) begin
          if (shadow_table[i] == ENTRY_FREE) r.free_total++;
          else if (shadow_table[i] == ENTRY_BAD) r.bad_total++;
          else r.used_total++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one command with random idle time and waits for its transfer.
  task automatic send_command(cmd_row_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c.cmd;
    in_block_number <= c.blk;
    in_entry_value <= c.val;
    in_block_count <= c.cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_command(c));
  endtask

  // Writes one register while the block is idle.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SEARCH_START) shadow_start = data[BLK_W-1:0];
    else shadow_max = data;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic cmd_row_t random_command();
    cmd_row_t c;
    int pick;
    c.cmd = CMD_WRITE;
    c.blk = BLK_W'($urandom);
    c.val = ENTRY_W'($urandom);
    c.cnt = CNT_W'($urandom_range(1, 24));
    pick = $urandom_range(99);
    if (pick < 25) begin
      c.cmd = CMD_ALLOC;
      if ($urandom_range(9) == 0) c.cnt = CNT_W'($urandom);
    end else if (pick < 45) begin
      // Free the head of a likely chain most of the time.
      c.cmd = CMD_FREE;
      if ($urandom_range(3) != 0) c.blk = BLK_W'(shadow_start + $urandom_range(40));
    end else if (pick < 60) begin
      c.cmd = CMD_READ;
      if ($urandom_range(1)) c.blk = BLK_W'(shadow_start + $urandom_range(40));
    end else if (pick < 70) begin
      c.cmd = CMD_STATS;
    end else if (pick < 94) begin
      // Writes mostly of special codes or in-table links.
      case ($urandom_range(3))
        0: c.val = ENTRY_BAD;
        1: c.val = ENTRY_END;
        2: c.val = ENTRY_W'($urandom_range(NBLK - 1));
        default: ;
      endcase
    end else begin
      c.cmd = CMD_W'($urandom_range(5, 7));
    end
    return c;
  endfunction

  // Result side: random stalls, long hold-off on request, check in order.
  initial begin
    res_t exp_r;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, out_status);
            fail_count++;
          end
          if (out_result_value !== exp_r.value) begin
            $error("result_value exp %0h got %0h", exp_r.value, out_result_value);
            fail_count++;
          end
          if (out_freed_count !== exp_r.freed) begin
            $error("freed_count exp %0d got %0d", exp_r.freed, out_freed_count);
            fail_count++;
          end
          if (out_free_total !== exp_r.free_total) begin
            $error("free_total exp %0d got %0d", exp_r.free_total, out_free_total);
            fail_count++;
          end
          if (out_used_total !== exp_r.used_total) begin
            $error("used_total exp %0d got %0d", exp_r.used_total, out_used_total);
            fail_count++;
          end
          if (out_bad_total !== exp_r.bad_total) begin
            $error("bad_total exp %0d got %0d", exp_r.bad_total, out_bad_total);
            fail_count++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stimulus.
  initial begin
    cmd_row_t directed [22] = '{
      '{CMD_READ,  12'd4095, 16'h0,    13'd1},
      '{CMD_STATS, 12'd0,    16'h0,    13'd1},
      '{CMD_WRITE, 12'd0,    16'h7FFF, 13'd1},
      '{CMD_WRITE, 12'd4095, 16'h8000, 13'd1},
      '{CMD_WRITE, 12'd100,  ENTRY_BAD, 13'd1},
      '{CMD_READ,  12'd0,    16'h0,    13'd1},
      '{CMD_READ,  12'd4095, 16'h0,    13'd1},
      '{CMD_ALLOC, 12'd0,    16'h0,    13'd0},
      '{CMD_ALLOC, 12'd0,    16'h0,    13'd4017},
      '{CMD_ALLOC, 12'd0,    16'h0,    13'd8191},
      '{CMD_ALLOC, 12'd0,    16'h0,    13'd5},
      '{CMD_READ,  12'd64,   16'h0,    13'd1},
      '{CMD_FREE,  12'd64,   16'h0,    13'd1},
      '{CMD_WRITE, 12'd200,  16'd200,  13'd1},
      '{CMD_FREE,  12'd200,  16'h0,    13'd1},
      '{CMD_WRITE, 12'd300,  16'd5000, 13'd1},
      '{CMD_FREE,  12'd300,  16'h0,    13'd1},
      '{CMD_ALLOC, 12'd0,    16'h0,    13'd4016},
      '{CMD_STATS, 12'd0,    16'h0,    13'd1},
      '{3'd5,      12'hFFF,  16'hFFFF, 13'h1FFF},
      '{3'd7,      12'd1,    16'h1,    13'd1},
      '{CMD_FREE,  12'd0,    16'h0,    13'd1}
    };
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_block_number = '0;
    in_entry_value = '0;
    in_block_count = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    shadow_start = START_RESET;
    shadow_max = MAX_RESET;
    for (int i = 0; i < NBLK; i++) shadow_table[i] = ENTRY_FREE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; the first two rows and the zero and oversized requests are typed in.
    foreach (directed[k]) begin
      send_command(directed[k]);
      if (k == 0)
        pending_results[pending_results.size() - 1] =
          res_t'{status: ST_OK, default: '0};
      if (k == 1)
        pending_results[pending_results.size() - 1] =
          res_t'{status: ST_OK, free_total: 13'd4096, default: '0};
      if (k >= 7 && k <= 9)
        pending_results[pending_results.size() - 1] =
          res_t'{status: ST_TOO_LARGE, value: ENTRY_END, default: '0};
    end
    wait_drained();

    // Extremes of the registers, then short chains from a low start.
    write_register(CFG_SEARCH_START, 13'd4095);
    write_register(CFG_MAX_ALLOC, 13'd4096);
    send_command('{CMD_ALLOC, 12'd0, 16'h0, 13'd1});
    send_command('{CMD_ALLOC, 12'd0, 16'h0, 13'd4096});
    wait_drained();
    write_register(CFG_SEARCH_START, 13'd0);
    write_register(CFG_MAX_ALLOC, 13'd1);
    send_command('{CMD_ALLOC, 12'd0, 16'h0, 13'd2});
    send_command('{CMD_ALLOC, 12'd0, 16'h0, 13'd1});
    wait_drained();
    write_register(CFG_SEARCH_START, 13'd64);
    write_register(CFG_MAX_ALLOC, 13'd32);

    // Random phases with different idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        3: begin send_idle_pct = 30; recv_stall_pct = 30; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 20000; end
      endcase
      for (int n = 0; n < 23; n++) send_command(random_command());
      wait_drained();
      if (ph == 1) write_register(CFG_SEARCH_START, CNT_W'($urandom_range(0, 200)));
      if (ph == 3) write_register(CFG_MAX_ALLOC, CNT_W'($urandom_range(1, 40)));
    end

    if (fail_count == 0) begin
      $display("block_chain_allocation_table_top verification clean");
    end else begin
      $display("block_chain_allocation_table_top verification failed");
    end
    $finish;
  end

endmodule
